/* rtl/core/slpa_pkg.sv */
// Shared sizes, reset values and register indexes for the sound level envelope.
// No dependencies; imported by the sound_level_peak_average top level.
package slpa_pkg;

	localparam int RING_DEPTH  = 10;
	localparam int SAMPLE_BITS = 10;

	localparam int FIELD_BITS   = 10;
	localparam int CFG_IDX_BITS = 1;
	localparam int POS_BITS     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_BITS     = $clog2(RING_DEPTH << SAMPLE_BITS);
	localparam int MAX_SUM      = RING_DEPTH * ((1 << SAMPLE_BITS) - 1);
	localparam int CMP_BITS     = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

	// floor(2^SUM_BITS / RING_DEPTH): the estimate is low by at most one
	localparam int RECIP       = (1 << SUM_BITS) / RING_DEPTH;
	localparam int RECIP_BITS  = $clog2(RECIP + 1);
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

	localparam logic [FIELD_BITS-1:0] NOISE_RESET   = FIELD_BITS'(560);
	localparam logic [FIELD_BITS-1:0] SILENCE_RESET = FIELD_BITS'(550);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NOISE   = 1'b0,
		REG_SILENCE = 1'b1
	} reg_idx_t;

endpackage

/* rtl/core/sound_level_peak_average.sv */
// Sound level envelope: windowed peak, ring of recent peaks, averaged level vs thresholds.
// Depends on slpa_pkg for sizes, reset values and register indexes.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-----------------------------------
//  input     | sample_valid / sample_ready | sample, window_end
//  result    | result_valid / result_ready | level, above_noise, above_silence
//  config    | cfg_we (no wait)            | cfg_index, cfg_data
//
// One input item per cycle sustained while the result side accepts results. A window-closing
// item passes through registered steps after its transfer: ring memory read, sum update and write-back, reciprocal
// multiply, then quotient correction and threshold compare into the output register.
// Ring slots carry valid bits cleared by reset, so there is no clearing pass.
// A stalled result holds only the stages behind it that are occupied; empty stages
// keep taking items.
module sound_level_peak_average (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic [slpa_pkg::FIELD_BITS-1:0]   sample,
	input  logic                              window_end,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [slpa_pkg::FIELD_BITS-1:0]   level,
	output logic                              above_noise,
	output logic                              above_silence,
	input  logic                              cfg_we,
	input  logic [slpa_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [slpa_pkg::FIELD_BITS-1:0]   cfg_data
);
	import slpa_pkg::*;

	logic [FIELD_BITS-1:0]  noise_q, silence_q;
	logic [SAMPLE_BITS-1:0] peak_q, samp, cand;
	logic [POS_BITS-1:0]    pos_q;
	logic [SUM_BITS-1:0]    sum_q, sum_new;
	logic [RING_DEPTH-1:0]  slot_vld_q;

	logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

	logic                   v1_q, v2_q, v3_q, res_v_q;
	logic                   ld1, ld2, ld3, ld_out, in_xfer, close_xfer;

	logic [SAMPLE_BITS-1:0] peak_s1, old_s1;
	logic [POS_BITS-1:0]    pos_s1;
	logic                   old_vld_s1;
	logic [SUM_BITS-1:0]    sum_s2, sum_s3;
	logic [PROD_BITS-1:0]   prod_s3;

	logic [SAMPLE_BITS-1:0] q_est, lvl;
	logic [SUM_BITS-1:0]    rem;
	logic [FIELD_BITS-1:0]  level_q;
	logic                   above_noise_q, above_silence_q;

	// stage load enables: a stage loads when empty or when its content moves on
	assign ld_out = !res_v_q || result_ready;
	assign ld3    = !v3_q || ld_out;
	assign ld2    = !v2_q || ld3;
	assign ld1    = !v1_q || ld2;

	assign sample_ready = ld1;
	assign in_xfer      = sample_valid && sample_ready;
	assign close_xfer   = in_xfer && window_end;

	assign samp = SAMPLE_BITS'(sample);
	assign cand = (samp > peak_q) ? samp : peak_q;

	// drop the overwritten peak, add the new one
	assign sum_new = sum_q - (old_vld_s1 ? SUM_BITS'(old_s1) : '0) + SUM_BITS'(peak_s1);

	// quotient estimate is floor or floor-1; one compare fixes it
	assign q_est = prod_s3[SUM_BITS +: SAMPLE_BITS];
	assign rem   = sum_s3 - SUM_BITS'(q_est) * SUM_BITS'(RING_DEPTH);
	assign lvl   = (rem >= SUM_BITS'(RING_DEPTH)) ? q_est + SAMPLE_BITS'(1) : q_est;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q    <= NOISE_RESET;
			silence_q  <= SILENCE_RESET;
			peak_q     <= '0;
			pos_q      <= '0;
			sum_q      <= '0;
			slot_vld_q <= '0;
			v1_q       <= 1'b0;
			v2_q       <= 1'b0;
			v3_q       <= 1'b0;
			res_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_NOISE:   noise_q   <= cfg_data;
					REG_SILENCE: silence_q <= cfg_data;
					default:     ;
				endcase
			end
			if (in_xfer) begin
				peak_q <= window_end ? '0 : cand;
				if (window_end) begin
					pos_q <= (pos_q == POS_BITS'(RING_DEPTH - 1)) ? '0 : pos_q + POS_BITS'(1);
				end
			end
			if (v1_q && ld2) begin
				sum_q              <= sum_new;
				slot_vld_q[pos_s1] <= 1'b1;
			end
			if (ld1)    v1_q    <= close_xfer;
			if (ld2)    v2_q    <= v1_q;
			if (ld3)    v3_q    <= v2_q;
			if (ld_out) res_v_q <= v3_q;
		end
	end

	// ring memory: read on a closing transfer, write back when stage 1 advances
	always_ff @(posedge clk) begin
		if (close_xfer) begin
			old_s1     <= ring_mem[pos_q];
			old_vld_s1 <= slot_vld_q[pos_q];
			peak_s1    <= cand;
			pos_s1     <= pos_q;
		end
		if (v1_q && ld2) begin
			ring_mem[pos_s1] <= peak_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2 && v1_q) begin
			sum_s2 <= sum_new;
		end
		if (ld3 && v2_q) begin
			sum_s3  <= sum_s2;
			prod_s3 <= PROD_BITS'(sum_s2) * PROD_BITS'(RECIP);
		end
		if (ld_out && v3_q) begin
			level_q         <= FIELD_BITS'(lvl);
			above_noise_q   <= CMP_BITS'(lvl) > CMP_BITS'(noise_q);
			above_silence_q <= CMP_BITS'(lvl) > CMP_BITS'(silence_q);
		end
	end

	assign result_valid  = res_v_q;
	assign level         = level_q;
	assign above_noise   = above_noise_q;
	assign above_silence = above_silence_q;

	// an open window never loses a larger sample
	a_peak_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !window_end |=> peak_q >= $past(samp))
		else $error("window peak dropped below a transferred sample");

	// every closing transfer enters the ring stage
	a_close_enters: assert property (@(posedge clk) disable iff (!arst_n)
		close_xfer |=> v1_q)
		else $error("closing transfer did not reach ring stage");

	// running sum stays within the ring's capacity
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_BITS'(MAX_SUM))
		else $error("peak sum out of range");

	// an open window is cleared by its closing transfer
	a_peak_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		close_xfer |=> peak_q == '0)
		else $error("window peak not cleared at window close");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for sound_level_peak_average: windowed peak, ten-peak ring average.
// Depends on slpa_pkg and the sound_level_peak_average RTL; predicts every level result locally.
module testbench;
	import slpa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [FIELD_BITS-1:0] level;
		logic                  above_noise;
		logic                  above_silence;
	} level_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    sample_valid = 1'b0;
	logic                    sample_ready;
	logic [FIELD_BITS-1:0]   sample = '0;
	logic                    window_end = 1'b0;
	logic                    result_valid;
	logic                    result_ready = 1'b0;
	logic [FIELD_BITS-1:0]   level;
	logic                    above_noise;
	logic                    above_silence;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [FIELD_BITS-1:0]   cfg_data = '0;

	// local copy of the envelope state
	logic [FIELD_BITS-1:0] noise_limit = NOISE_RESET;
	logic [FIELD_BITS-1:0] silence_limit = SILENCE_RESET;
	int                    open_peak = 0;
	int                    recent_peaks [RING_DEPTH] = '{default: 0};
	int                    ring_slot = 0;
	int                    peak_total = 0;
	level_result_t         pending_levels [$];

	int send_idle_pct = 7;
	int recv_idle_pct = 50;
	int hold_request = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int fail_count = 0;
	int samples_sent = 0;
	int levels_checked = 0;
	int reg_writes = 0;

	sound_level_peak_average uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.window_end(window_end),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.level(level),
		.above_noise(above_noise),
		.above_silence(above_silence),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d levels outstanding", cycle_count,
				pending_levels.size());
			$display("status: fail");
			$finish;
		end
	end

	// Fold one accepted sample into the window peak; a window close yields one level.
	function automatic void track_sample(input logic [FIELD_BITS-1:0] s, input logic e);
		level_result_t r;
		int avg;
		if (int'(s) > open_peak)
			open_peak = int'(s);
		if (!e)
			return;
		peak_total = peak_total - recent_peaks[ring_slot] + open_peak;
		recent_peaks[ring_slot] = open_peak;
		ring_slot = (ring_slot + 1) % RING_DEPTH;
		open_peak = 0;
		avg = peak_total / RING_DEPTH;
		r.level = avg[FIELD_BITS-1:0];
		r.above_noise = avg > int'(noise_limit);
		r.above_silence = avg > int'(silence_limit);
		pending_levels.push_back(r);
	endfunction

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			if (pending_levels.size() == 0) begin
				$error("unexpected result: level %0d, above_noise %0b, above_silence %0b",
					level, above_noise, above_silence);
				fail_count++;
			end else begin
				level_result_t exp_r;
				exp_r = pending_levels.pop_front();
				levels_checked++;
				if (level !== exp_r.level) begin
					$error("level: expected %0d, got %0d", exp_r.level, level);
					fail_count++;
				end
				if (above_noise !== exp_r.above_noise) begin
					$error("above_noise: expected %0b, got %0b", exp_r.above_noise, above_noise);
					fail_count++;
				end
				if (above_silence !== exp_r.above_silence) begin
					$error("above_silence: expected %0b, got %0b", exp_r.above_silence,
						above_silence);
					fail_count++;
				end
			end
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Call at a rising edge; returns at the edge of the transfer with valid still high.
	task automatic send_sample(input logic [FIELD_BITS-1:0] s, input logic e);
		int gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		window_end <= e;
		do @(posedge clk); while (!sample_ready);
		samples_sent++;
		track_sample(s, e);
	endtask

	// Stop offering, wait for every level, then let the design settle.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [FIELD_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NOISE)
			noise_limit = value;
		else
			silence_limit = value;
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic set_thresholds(input logic [FIELD_BITS-1:0] noise_val,
			input logic [FIELD_BITS-1:0] silence_val);
		wait_idle();
		write_reg(REG_NOISE, noise_val);
		write_reg(REG_SILENCE, silence_val);
	endtask

	function automatic int pick_near(input int center);
		int v;
		v = center + $urandom_range(0, 40) - 20;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return v;
	endfunction

	// One window whose peak is exactly top, placed at a random position.
	task automatic send_window(input int top, input int len);
		int top_pos;
		top_pos = $urandom_range(0, len - 1);
		for (int i = 0; i < len; i++)
			send_sample(FIELD_BITS'((i == top_pos) ? top : $urandom_range(0, top)),
				i == len - 1);
	endtask

	// Directed: single-item windows, extremes, peak placement, ring fill and wrap.
	task automatic test_directed();
		send_sample(0, 1'b1);
		send_sample(1023, 1'b1);
		send_sample(512, 1'b0);
		send_sample(1000, 1'b0);
		send_sample(3, 1'b1);
		send_sample(100, 1'b0);
		send_sample(700, 1'b1);
		send_sample(682, 1'b0);
		send_sample(341, 1'b1);
		// fill the whole ring with full-scale peaks, then wrap with a zero
		repeat (RING_DEPTH) send_sample(1023, 1'b1);
		send_sample(0, 1'b1);
		wait_idle();
	endtask

	// Extreme and inverted threshold settings against uniform windows.
	task automatic test_threshold_extremes();
		set_thresholds(0, 0);
		repeat (20) send_window($urandom_range(0, 1023), $urandom_range(1, 5));
		set_thresholds(1023, 1023);
		repeat (10) send_window(1023, 1);
		repeat (10) send_window($urandom_range(0, 1023), $urandom_range(1, 5));
		set_thresholds(300, 700);
		repeat (20) send_window($urandom_range(0, 1023), $urandom_range(1, 5));
		set_thresholds(1023, 0);
		repeat (20) send_window($urandom_range(0, 1023), $urandom_range(1, 4));
	endtask

	// Hold the result side off while closing windows keep coming, so the input stalls.
	task automatic test_backpressure();
		set_thresholds(560, 550);
		hold_request = 80;
		repeat (40) send_sample(FIELD_BITS'($urandom_range(0, 1023)), 1'b1);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int item_goal);
		int start_count;
		int len;
		int top;
		int pick;
		start_count = samples_sent;
		set_thresholds(FIELD_BITS'($urandom_range(0, 1023)), FIELD_BITS'($urandom_range(0, 1023)));
		while (samples_sent - start_count < item_goal) begin
			pick = $urandom_range(0, 99);
			len = (pick < 70) ? $urandom_range(1, 4) :
				(pick < 95) ? $urandom_range(5, 12) : $urandom_range(13, 40);
			pick = $urandom_range(0, 99);
			if (pick < 40)
				top = pick_near(int'(noise_limit));
			else if (pick < 60)
				top = pick_near(int'(silence_limit));
			else if (pick < 90)
				top = $urandom_range(0, 1023);
			else
				top = (pick < 95) ? 1023 : 0;
			send_window(top, len);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 7;
		recv_idle_pct = 50;
		test_directed();
		test_threshold_extremes();
		test_backpressure();
		test_random_traffic(370);

		send_idle_pct = 50;
		recv_idle_pct = 7;
		test_random_traffic(370);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(370);

		wait_idle();
		$display("covered %0d sample transfers and %0d register writes over several thresholds",
			samples_sent, reg_writes);
		$display("checked %0d level results, %0d mismatches", levels_checked, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/slpa_pkg.sv
rtl/core/sound_level_peak_average.sv
tb/testbench.sv
